@@ hw/rtl/rpnee_pkg.sv @@
package rpnee_pkg;

	// Operation codes carried by an input beat
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_END  = 3'd5;

	// Status codes of a result beat
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	localparam int unsigned DATA_W = 32;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [DATA_W-1:0] number;
	} token_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] answer;
	} result_t;

	// Decoded token class, produced by the front end
	typedef enum logic [2:0] {
		K_PUSH,
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_END,
		K_UNKNOWN
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [DATA_W-1:0] number;
	} cmd_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic              negative;
		logic [DATA_W-1:0] lhs_mag;
		logic [DATA_W-1:0] rhs_mag;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quot;
	} div_rsp_t;

	// Saturate a 33-bit sum or difference to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
		logic signed [DATA_W-1:0] r;
		if (s[DATA_W] != s[DATA_W-1]) begin
			r = s[DATA_W] ? Q_MIN : Q_MAX;
		end else begin
			r = s[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/rpnee_front.sv @@
module rpnee_front
	import rpnee_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  token_t token,
	output logic   busy,
	input  logic   pop,
	output logic   cmd_valid,
	output cmd_t   cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       do_pop;
	cmd_t       decoded;

	// Classify the incoming token
	always_comb begin
		decoded.number = token.number;
		unique case (token.operation)
			OP_PUSH: decoded.kind = K_PUSH;
			OP_ADD:  decoded.kind = K_ADD;
			OP_SUB:  decoded.kind = K_SUB;
			OP_MUL:  decoded.kind = K_MUL;
			OP_DIV:  decoded.kind = K_DIV;
			OP_END:  decoded.kind = K_END;
			default: decoded.kind = K_UNKNOWN;
		endcase
	end

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign do_pop    = pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= decoded;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

@@ hw/rtl/rpnee_div.sv @@
module rpnee_div
	import rpnee_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_t;

	dv_state_t         state_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] divisor_q;
	logic [4:0]        step_q;
	logic              neg_q;
	logic              sat_q;

	logic [2*DATA_W-1:0] numer;
	logic [DATA_W:0]     trial;
	logic                fits;

	// Scaled dividend and one restoring step
	assign numer = {{DATA_W{1'b0}}, req.lhs_mag} << FRAC_BITS;
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign fits  = (trial >= {1'b0, divisor_q});

	// Sign and saturation of the finished quotient
	always_comb begin
		rsp.done = (state_q == DV_DONE);
		if (sat_q) begin
			rsp.quot = neg_q ? Q_MIN : Q_MAX;
		end else if (!neg_q) begin
			rsp.quot = quo_q[DATA_W-1] ? Q_MAX : quo_q;
		end else if (quo_q > Q_MIN) begin
			rsp.quot = Q_MIN;
		end else begin
			rsp.quot = -quo_q;
		end
	end

	// One quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= DV_IDLE;
			rem_q     <= '0;
			quo_q     <= '0;
			divisor_q <= '0;
			step_q    <= '0;
			neg_q     <= 1'b0;
			sat_q     <= 1'b0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						divisor_q <= req.rhs_mag;
						neg_q     <= req.negative;
						rem_q     <= numer[2*DATA_W-1:DATA_W];
						quo_q     <= numer[DATA_W-1:0];
						step_q    <= '0;
						// quotient of 2^32 or more: saturate at once
						if (numer[2*DATA_W-1:DATA_W] >= req.rhs_mag) begin
							sat_q   <= 1'b1;
							state_q <= DV_DONE;
						end else begin
							sat_q   <= 1'b0;
							state_q <= DV_RUN;
						end
					end
				end
				DV_RUN: begin
					rem_q  <= fits ? (trial[DATA_W-1:0] - divisor_q) : trial[DATA_W-1:0];
					quo_q  <= {quo_q[DATA_W-2:0], fits};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= DV_DONE;
					end
				end
				DV_DONE: begin
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/rpnee_back.sv @@
module rpnee_back
	import rpnee_pkg::*;
#(
	parameter int STACK_DEPTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	input  cmd_t    cmd,
	output logic    pop,
	output logic    done,
	output result_t result
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [2*DATA_W-1:0] FracMask = (64'd1 << FRAC_BITS) - 64'd1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_MUL,
		B_DIV
	} b_state_t;

	b_state_t                   state_q;
	cmd_t                       cmd_q;
	logic [CNT_W-1:0]           count_q;
	logic [2:0]                 err_q;
	logic signed [DATA_W-1:0]   tos_q;
	logic signed [DATA_W-1:0]   nos_q;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic                       done_q;
	result_t                    result_q;

	logic signed [DATA_W-1:0]   mem [STACK_DEPTH];
	logic signed [DATA_W-1:0]   rdata_q;
	logic                       mem_we;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr;
	logic [CNT_W-1:0]           wr_idx;
	logic [CNT_W-1:0]           rd_idx;

	logic                       two_ops;
	logic                       full;
	logic [2:0]                 err_next_div;
	logic [2:0]                 err_next_unk;
	logic [2:0]                 err_next_ovf;
	logic signed [DATA_W:0]     sum;
	logic signed [DATA_W:0]     diff;
	logic signed [2*DATA_W-1:0] shifted;
	logic signed [2*DATA_W-1:0] scaled;
	logic                       mul_fits;
	logic signed [DATA_W-1:0]   mul_res;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	// Top two entries live in tos_q/nos_q, deeper ones in the memory
	assign wr_idx  = count_q - CNT_W'(2);
	assign rd_idx  = count_q - CNT_W'(3);
	assign wr_addr = wr_idx[AW-1:0];
	assign rd_addr = rd_idx[AW-1:0];
	assign two_ops = (count_q >= CNT_W'(2));
	assign full    = (count_q == CNT_W'(STACK_DEPTH));
	assign mem_we  = (state_q == B_EXEC) && (cmd_q.kind == K_PUSH) && !full && two_ops;

	assign err_next_div = (err_q == ST_OK) ? ST_DIVZERO  : err_q;
	assign err_next_unk = (err_q == ST_OK) ? ST_UNKNOWN  : err_q;
	assign err_next_ovf = (err_q == ST_OK) ? ST_OVERFLOW : err_q;

	// Add and subtract, left operand is the entry under the top
	assign sum  = {nos_q[DATA_W-1], nos_q} + {tos_q[DATA_W-1], tos_q};
	assign diff = {nos_q[DATA_W-1], nos_q} - {tos_q[DATA_W-1], tos_q};

	// Product scaling, truncated toward zero, then saturated
	always_comb begin
		shifted  = prod_s1 >>> FRAC_BITS;
		scaled   = shifted + (((prod_s1 < 0) && ((prod_s1 & FracMask) != '0)) ? 64'sd1 : 64'sd0);
		mul_fits = (scaled[2*DATA_W-1:DATA_W-1] == '0) || (scaled[2*DATA_W-1:DATA_W-1] == '1);
		if (mul_fits) begin
			mul_res = scaled[DATA_W-1:0];
		end else begin
			mul_res = scaled[2*DATA_W-1] ? Q_MIN : Q_MAX;
		end
	end

	// Divider launch
	always_comb begin
		div_req.start    = (state_q == B_EXEC) && (cmd_q.kind == K_DIV) && two_ops && (tos_q != '0);
		div_req.negative = nos_q[DATA_W-1] ^ tos_q[DATA_W-1];
		div_req.lhs_mag  = nos_q[DATA_W-1] ? -nos_q : nos_q;
		div_req.rhs_mag  = tos_q[DATA_W-1] ? -tos_q : tos_q;
	end

	rpnee_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign pop    = (state_q == B_IDLE) && cmd_valid;
	assign done   = done_q;
	assign result = result_q;

	// Operand stack memory, refill port always reads the third entry from the top
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= nos_q;
		end
		rdata_q <= mem[rd_addr];
	end

	// Execution sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cmd_q    <= '{kind: K_PUSH, number: '0};
			count_q  <= '0;
			err_q    <= ST_OK;
			tos_q    <= '0;
			nos_q    <= '0;
			prod_s1  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					state_q <= B_IDLE;
					unique case (cmd_q.kind)
						K_PUSH: begin
							if (full) begin
								err_q <= err_next_ovf;
							end else begin
								nos_q   <= tos_q;
								tos_q   <= cmd_q.number;
								count_q <= count_q + CNT_W'(1);
							end
						end
						K_END: begin
							done_q <= 1'b1;
							if (err_q != ST_OK) begin
								result_q <= '{status: err_q, answer: '0};
							end else if (count_q == CNT_W'(1)) begin
								result_q <= '{status: ST_OK, answer: tos_q};
							end else begin
								result_q <= '{status: ST_MALFORMED, answer: '0};
							end
							count_q <= '0;
							err_q   <= ST_OK;
						end
						K_ADD: begin
							if (two_ops) begin
								tos_q   <= sat33(sum);
								nos_q   <= rdata_q;
								count_q <= count_q - CNT_W'(1);
							end
						end
						K_SUB: begin
							if (two_ops) begin
								tos_q   <= sat33(diff);
								nos_q   <= rdata_q;
								count_q <= count_q - CNT_W'(1);
							end
						end
						K_MUL: begin
							if (two_ops) begin
								prod_s1 <= nos_q * tos_q;
								state_q <= B_MUL;
							end
						end
						K_DIV: begin
							if (two_ops) begin
								if (tos_q == '0) begin
									err_q <= err_next_div;
								end else begin
									state_q <= B_DIV;
								end
							end
						end
						default: begin
							if (two_ops) begin
								err_q <= err_next_unk;
							end
						end
					endcase
				end
				B_MUL: begin
					tos_q   <= mul_res;
					nos_q   <= rdata_q;
					count_q <= count_q - CNT_W'(1);
					state_q <= B_IDLE;
				end
				B_DIV: begin
					if (div_rsp.done) begin
						tos_q   <= div_rsp.quot;
						nos_q   <= rdata_q;
						count_q <= count_q - CNT_W'(1);
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/rpn_expression_evaluator_unit.sv @@
// Channel   Handshake              Beat
// -------   --------------------   -----------------------------------
// token     start high, busy low   token_t: operation, number (Q16.16)
// result    done, one cycle        result_t: status, answer (Q16.16)
//
// A token is dequeued and then executed in the execution unit; a multiply
// then scales its product; a divide waits on the one-bit-a-cycle divider.
// A two-entry token queue sits in front; busy rises only while it is full.
// Reset clears the queue, stack count and sticky error; stack memory is
// not cleared. A result beat is shown for one cycle and cannot be stalled.
module rpn_expression_evaluator_unit
	import rpnee_pkg::*;
#(
	parameter int STACK_DEPTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  token_t  token,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic cmd_valid;
	logic pop;
	cmd_t cmd;

	// Accept and classify tokens into the queue
	rpnee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.token    (token),
		.busy     (busy),
		.pop      (pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	// Stack machine and arithmetic
	rpnee_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule
